[rtl/core/three_term_recurrence_checksum_unit_macros.svh]
// Assertion macros shared by the checksum unit RTL.
`ifndef THREE_TERM_RECURRENCE_CHECKSUM_UNIT_MACROS_SVH
`define THREE_TERM_RECURRENCE_CHECKSUM_UNIT_MACROS_SVH

// Same-cycle implication, checked on the clock edge and disabled in reset.
`define TTRC_ASSERT_NOW(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the clock edge and disabled in reset.
`define TTRC_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/ttrc_pkg.sv]
// Types, constants and coefficient functions for the recurrence checksum unit.
package ttrc_pkg;

    localparam logic [15:0] MODULUS      = 16'hFFFF;
    localparam logic [15:0] FIRST_OFFSET = 16'd7;
    localparam logic [15:0] COEF_A       = 16'd17;
    localparam logic [15:0] COEF_B       = 16'd31;
    localparam logic [15:0] OLDER_INIT   = 16'd1;
    localparam logic [15:0] NEWER_INIT   = 16'd1;
    // A multiple of the modulus larger than any product, plus one, used to fold
    // a negative difference (wrapped modulo 2^64) back into a positive value.
    localparam logic [24:0] WRAP_BIAS    = 25'(65535 * 512 + 1);

    typedef struct packed {
        logic [15:0] older;
        logic [15:0] newer;
        logic [7:0]  position;
        logic        first;
    } term_state_t;

    function automatic logic [7:0] coef_a(input logic [7:0] pos);
        logic [15:0] prod;
        prod = {8'd0, pos} * COEF_A;
        return prod[7:0];
    endfunction

    function automatic logic [7:0] coef_b(input logic [7:0] pos);
        logic [15:0] prod;
        prod = {8'd0, pos} * COEF_B;
        return prod[7:0];
    endfunction

endpackage

[rtl/core/ttrc_term.sv]
// Combinational next-term computation of the recurrence modulo 65535.
module ttrc_term
(
    input  logic [7:0]               data_byte,
    input  ttrc_pkg::term_state_t    state,
    output logic [15:0]              next_term
);

    logic [8:0]  a_coef;
    logic [7:0]  b_coef;
    logic [24:0] plus;
    logic [24:0] minus;
    logic        is_neg;
    logic [24:0] folded;
    logic [16:0] partial;

    always_comb
    begin
        a_coef = {1'b0, data_byte} + {1'b0, ttrc_pkg::coef_a(state.position)};
        b_coef = ttrc_pkg::coef_b(state.position);
        plus   = {16'd0, a_coef} * {9'd0, state.newer};
        minus  = {17'd0, b_coef} * {9'd0, state.older};
        is_neg = plus < minus;
        // A negative difference is congruent to one minus its magnitude.
        if (is_neg)
        begin
            folded = ttrc_pkg::WRAP_BIAS - (minus - plus);
        end
        else
        begin
            folded = plus - minus;
        end
        // 2^16 is 1 modulo 65535, so the high bits fold onto the low half.
        partial = {1'b0, folded[15:0]} + {8'd0, folded[24:16]};
        if (partial >= {1'b0, ttrc_pkg::MODULUS})
        begin
            next_term = 16'(partial - {1'b0, ttrc_pkg::MODULUS});
        end
        else
        begin
            next_term = partial[15:0];
        end
    end

endmodule

[rtl/core/three_term_recurrence_checksum_unit.sv]
// Three-term recurrence checksum over a byte stream; each message yields one checksum beat.
// An input beat is registered; when it advances, the terms update and a final byte loads the result.
// One byte per cycle unless a final byte stalls; the term update loops through the state register.
// Only a final byte can stall on a full output register; other bytes always proceed.
// Reset (rst_n low, asynchronous) clears the valid flags and returns the terms to
// older = 1, newer = 1, position 0, awaiting the first byte of a message.
`include "three_term_recurrence_checksum_unit_macros.svh"

module three_term_recurrence_checksum_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] checksum
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    ttrc_pkg::term_state_t  state_reg;
    ttrc_pkg::term_state_t  state_next;
    logic                   out_valid_reg;
    logic [15:0]            out_data_reg;
    logic [15:0]            term;
    logic                   advance;
    logic                   in_take;

    ttrc_term u_term
    (
        .data_byte (in_byte_reg),
        .state     (state_reg),
        .next_term (term)
    );

    // A final byte waits only if the output register still holds an untaken beat.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            if (in_last_reg)
            begin
                state_next.older    = ttrc_pkg::OLDER_INIT;
                state_next.newer    = ttrc_pkg::NEWER_INIT;
                state_next.position = 8'd0;
                state_next.first    = 1'b1;
            end
            else if (state_reg.first)
            begin
                state_next.older    = ttrc_pkg::OLDER_INIT;
                state_next.newer    = {8'd0, in_byte_reg} + ttrc_pkg::FIRST_OFFSET;
                state_next.position = 8'd1;
                state_next.first    = 1'b0;
            end
            else
            begin
                state_next.older    = state_reg.newer;
                state_next.newer    = term;
                state_next.position = state_reg.position + 8'd1;
                state_next.first    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            state_reg.older    <= ttrc_pkg::OLDER_INIT;
            state_reg.newer    <= ttrc_pkg::NEWER_INIT;
            state_reg.position <= 8'd0;
            state_reg.first    <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
        begin
            out_data_reg <= state_reg.first ? ({8'd0, in_byte_reg} + ttrc_pkg::FIRST_OFFSET)
                                            : term;
        end
    end

    `TTRC_ASSERT_NEXT(a_last_loads_out, clk, rst_n, advance && in_last_reg, out_valid_reg, "final byte did not produce a checksum beat")
    `TTRC_ASSERT_NEXT(a_last_rearms, clk, rst_n, advance && in_last_reg, state_reg.first, "state not returned to first-byte after a final byte")
    `TTRC_ASSERT_NOW(a_out_in_range, clk, rst_n, out_valid_reg, out_data_reg != ttrc_pkg::MODULUS, "checksum out of range")
    `TTRC_ASSERT_NOW(a_term_in_range, clk, rst_n, !state_reg.first, state_reg.newer != ttrc_pkg::MODULUS, "newer term out of range")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the three-term recurrence checksum unit.

class checksum_scoreboard;
    logic [15:0] older_term;
    logic [15:0] newer_term;
    logic [7:0]  position;
    bit          awaiting_first;
    logic [15:0] expected_sums[$];
    int          errors;

    function new();
        restart();
        errors = 0;
    endfunction

    function void restart();
        older_term     = ttrc_pkg::OLDER_INIT;
        newer_term     = ttrc_pkg::NEWER_INIT;
        position       = 8'd0;
        awaiting_first = 1'b1;
    endfunction

    // Term that a byte would produce at the current position, without updating state.
    function logic [15:0] peek_term(logic [7:0] data_byte);
        logic [8:0]      coef_sum;
        logic [7:0]      coef_diff;
        longint unsigned plus;
        longint unsigned minus;
        longint unsigned modulus;
        modulus   = 64'(ttrc_pkg::MODULUS);
        coef_sum  = 9'(data_byte) + 9'(8'(position * ttrc_pkg::COEF_A));
        coef_diff = 8'(position * ttrc_pkg::COEF_B);
        plus      = 64'(coef_sum) * 64'(newer_term);
        minus     = 64'(coef_diff) * 64'(older_term);
        if (plus >= minus)
            return 16'((plus - minus) % modulus);
        // A negative difference wraps modulo 2^64, which is one more than a multiple
        // of the modulus.
        return 16'((modulus + 64'd1 - (minus - plus) % modulus) % modulus);
    endfunction

    function void note_beat(logic [7:0] data_byte, logic last_byte);
        logic [15:0] next;
        if (awaiting_first)
        begin
            older_term     = ttrc_pkg::OLDER_INIT;
            newer_term     = 16'(data_byte) + ttrc_pkg::FIRST_OFFSET;
            position       = 8'd1;
            awaiting_first = 1'b0;
        end
        else
        begin
            next       = peek_term(data_byte);
            older_term = newer_term;
            newer_term = next;
            position   = position + 8'd1;
        end
        if (last_byte)
        begin
            expected_sums.push_back(newer_term);
            restart();
        end
    endfunction

    function void check_result(logic [15:0] got);
        logic [15:0] want;
        if (expected_sums.size() == 0)
        begin
            $error("checksum: expected none, actual %0d", got);
            errors++;
            return;
        end
        want = expected_sums.pop_front();
        if (got !== want)
        begin
            $error("checksum: expected %0d, actual %0d", want, got);
            errors++;
        end
    endfunction

    function int pending();
        return expected_sums.size();
    endfunction
endclass

module tb_top;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 200;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    checksum_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    three_term_recurrence_checksum_unit DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Each task call starts just after a rising edge and returns just after the
    // edge that accepted the beat.
    task automatic send_beat(input logic [7:0] data_byte, input logic last_byte);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= data_byte;
        s_tlast  <= last_byte;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_beat(data_byte, last_byte);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_beat(8'($urandom_range(255)), i == len - 1);
    endtask

    task automatic send_random_messages(input int budget);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_message($urandom_range(1, 3));
            else if (pick < 85)
                send_message($urandom_range(4, 16));
            else
                send_message($urandom_range(17, 60));
        end
    endtask

    // Receiver: a pending hold-off wins over the random stall.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("three_term_recurrence_checksum_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        int idle_table[4];
        int stall_table[4];
        int best;
        idle_table  = '{0, 59, 0, 21};
        stall_table = '{0, 0, 59, 21};
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One-byte messages at both byte extremes, then short ones.
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(8'hAA, 1'b0);
        send_beat(8'h55, 1'b0);
        send_beat(8'h0F, 1'b0);
        send_beat(8'hF0, 1'b1);

        // Drive the newer term high and then low, so the following byte sees a
        // large older term against a small newer one and the difference goes negative.
        send_beat(8'h00, 1'b0);
        best = 0;
        for (int c = 1; c < 256; c++)
            if (sb.peek_term(8'(c)) > sb.peek_term(8'(best)))
                best = c;
        send_beat(8'(best), 1'b0);
        best = 0;
        for (int c = 1; c < 256; c++)
            if (sb.peek_term(8'(c)) < sb.peek_term(8'(best)))
                best = c;
        send_beat(8'(best), 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);

        // A message long enough for the position to wrap.
        send_message(300);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_table[p];
            stall_pct     = stall_table[p];
            send_random_messages(55);
        end

        // Receiver holds off while one-byte messages keep coming, so the output
        // fills and the input stalls.
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = HOLD_CYCLES;
        repeat (12) send_message(1);
        send_message(5);

        send_idle_pct = 21;
        stall_pct     = 21;
        send_random_messages(35);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("three_term_recurrence_checksum_unit: match");
        else
            $display("three_term_recurrence_checksum_unit: mismatch");
        $finish;
    end
endmodule

[three_term_recurrence_checksum_unit.f]
+incdir+rtl/core
rtl/core/ttrc_pkg.sv
rtl/core/ttrc_term.sv
rtl/core/three_term_recurrence_checksum_unit.sv
verif/tb_top.sv
